### rtl/sat_pkg.sv
// shared widths, codes and types of the summed area table
package sat_pkg;

  localparam int FIELD_W   = 7;
  localparam int SUM_W     = 32;
  localparam int RECT_W    = 29;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LOADED = 2'd1,
    ST_BOUND      = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

### rtl/sat_channels.sv
// valid/ready channel interfaces for commands and rectangle results
interface sat_in_if #(
  parameter int SAMPLE_BITS = 16
);
  import sat_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [FIELD_W-1:0]            row_start;
  logic [FIELD_W-1:0]            col_start;
  logic [FIELD_W-1:0]            row_end;
  logic [FIELD_W-1:0]            col_end;

  modport source (
    output valid, command, sample, row_start, col_start, row_end, col_end,
    input  ready
  );
  modport sink (
    input  valid, command, sample, row_start, col_start, row_end, col_end,
    output ready
  );
endinterface

interface sat_out_if;
  import sat_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [RECT_W-1:0] rect_sum;
  logic [STATUS_W-1:0]      status;

  modport source (
    output valid, rect_sum, status,
    input  ready
  );
  modport sink (
    input  valid, rect_sum, status,
    output ready
  );
endinterface

### rtl/summed_area_table.sv
// summed area table top: load sequencer, query reader and result register
//
//  channel   dir  handshake        payload
//  cfg       in   cfg_we           cfg_index, cfg_data
//  in_ch     in   valid / ready    command, sample, row_start..col_end
//  out_ch    out  valid / ready    rect_sum, status
//
// a load reads the entry above, then writes back the new sum
// a query makes four corner reads through the one read port
// a rejected query skips the corner reads and goes straight to done
// one item at a time; the next is taken while a result waits in out_ch
// a stalled out_ch holds a finished query in its done state
// synchronous reset clears the load position and the loaded flag
module summed_area_table #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sat_pkg::FIELD_W-1:0]     cfg_data,
  sat_in_if.sink                          in_ch,
  sat_out_if.source                       out_ch
);
  import sat_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LD_WR = 4'b0010,
    S_Q_RD  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t             state_q;
  logic [FIELD_W-1:0] rows_in_use, cols_in_use;
  logic [FIELD_W-1:0] rows_eff, cols_eff;
  logic [FIELD_W-1:0] load_row, load_col;
  logic [SUM_W-1:0]   row_sum;
  logic               table_loaded;

  logic [AW-1:0]      ld_wr_addr;
  logic [SUM_W-1:0]   ld_sum;
  logic               ld_top;

  logic [FIELD_W-1:0] q_rs, q_cs, q_re, q_ce;
  logic [2:0]         k_q;
  logic               p_zero, p_neg;
  logic [SUM_W-1:0]   acc;
  status_t            q_status;

  logic               out_valid_q;
  logic [RECT_W-1:0]  out_sum_q;
  status_t            out_status_q;

  logic               ram_we;
  logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
  logic [SUM_W-1:0]   ram_wr_data, ram_rd_data;

  function automatic logic [AW-1:0] cell_addr(input logic [FIELD_W-1:0] r,
                                              input logic [FIELD_W-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  // register clamping
  always_comb begin
    if (rows_in_use == '0) rows_eff = FIELD_W'(1);
    else if (32'(rows_in_use) > MAX_ROWS) rows_eff = FIELD_W'(MAX_ROWS);
    else rows_eff = rows_in_use;
    if (cols_in_use == '0) cols_eff = FIELD_W'(1);
    else if (32'(cols_in_use) > MAX_COLS) cols_eff = FIELD_W'(MAX_COLS);
    else cols_eff = cols_in_use;
  end

  logic               in_xfer, ld_xfer, q_xfer;
  logic               restart;
  logic [FIELD_W-1:0] lr, lc, lr_m1;
  logic [FIELD_W:0]   col_inc, row_inc;
  logic [SUM_W-1:0]   sample_ext, rsum_new;
  logic               bound_bad;

  assign in_ch.ready = (state_q == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign ld_xfer     = in_xfer && (in_ch.command == CMD_LOAD);
  assign q_xfer      = in_xfer && (in_ch.command == CMD_QUERY);

  always_comb begin
    restart    = table_loaded || (load_row >= rows_eff) || (load_col >= cols_eff);
    lr         = restart ? '0 : load_row;
    lc         = restart ? '0 : load_col;
    lr_m1      = lr - FIELD_W'(1);
    sample_ext = SUM_W'(in_ch.sample);
    rsum_new   = ((restart || lc == '0) ? '0 : row_sum) + sample_ext;
    col_inc    = {1'b0, lc} + (FIELD_W+1)'(1);
    row_inc    = {1'b0, lr} + (FIELD_W+1)'(1);
    bound_bad  = (in_ch.row_start > rows_eff) || (in_ch.row_end > rows_eff) ||
                 (in_ch.col_start > cols_eff) || (in_ch.col_end > cols_eff);
  end

  // corner k: bit 1 picks the start row, bit 0 the start column
  logic [FIELD_W-1:0] cr, cc;
  logic               c_zero;
  always_comb begin
    cr     = k_q[1] ? q_rs : q_re;
    cc     = k_q[0] ? q_cs : q_ce;
    c_zero = (cr == '0) || (cc == '0);
  end

  always_comb begin
    if (state_q == S_Q_RD) begin
      ram_rd_addr = cell_addr(cr - FIELD_W'(1), cc - FIELD_W'(1));
    end else begin
      ram_rd_addr = cell_addr(lr_m1, lc);
    end
    ram_we      = (state_q == S_LD_WR);
    ram_wr_addr = ld_wr_addr;
    ram_wr_data = (ld_top ? '0 : ram_rd_data) + ld_sum;
  end

  sat_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  logic [SUM_W-1:0] term;
  assign term = p_zero ? '0 : ram_rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q      <= S_IDLE;
      rows_in_use  <= FIELD_W'(64);
      cols_in_use  <= FIELD_W'(64);
      load_row     <= '0;
      load_col     <= '0;
      row_sum      <= '0;
      table_loaded <= 1'b0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS: rows_in_use <= cfg_data;
          REG_COLS: cols_in_use <= cfg_data;
          default:  ;
        endcase
        load_row     <= '0;
        load_col     <= '0;
        row_sum      <= '0;
        table_loaded <= 1'b0;
      end else if (ld_xfer) begin
        if (col_inc >= {1'b0, cols_eff}) begin
          load_col <= '0;
          if (row_inc >= {1'b0, rows_eff}) begin
            load_row     <= '0;
            row_sum      <= '0;
            table_loaded <= 1'b1;
          end else begin
            load_row     <= row_inc[FIELD_W-1:0];
            row_sum      <= rsum_new;
            table_loaded <= 1'b0;
          end
        end else begin
          load_row     <= lr;
          load_col     <= col_inc[FIELD_W-1:0];
          row_sum      <= rsum_new;
          table_loaded <= 1'b0;
        end
      end

      out_valid_q <= (state_q == S_DONE) || (out_valid_q && !out_ch.ready);

      unique case (state_q)
        S_IDLE: begin
          if (ld_xfer) begin
            state_q <= S_LD_WR;
          end else if (q_xfer) begin
            k_q     <= '0;
            state_q <= (table_loaded && !bound_bad) ? S_Q_RD : S_DONE;
          end
        end
        S_LD_WR: state_q <= S_IDLE;
        S_Q_RD: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd4) state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ch.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ld_xfer) begin
      ld_wr_addr <= cell_addr(lr, lc);
      ld_sum     <= rsum_new;
      ld_top     <= (lr == '0);
    end
    if (q_xfer) begin
      q_rs <= in_ch.row_start;
      q_cs <= in_ch.col_start;
      q_re <= in_ch.row_end;
      q_ce <= in_ch.col_end;
      acc  <= '0;
      if (!table_loaded) q_status <= ST_NOT_LOADED;
      else if (bound_bad) q_status <= ST_BOUND;
      else q_status <= ST_OK;
    end
    if (state_q == S_Q_RD) begin
      p_zero <= c_zero;
      p_neg  <= k_q[0] ^ k_q[1];
      if (k_q != 3'd0) acc <= p_neg ? acc - term : acc + term;
    end
    if (state_q == S_DONE && (!out_valid_q || out_ch.ready)) begin
      out_sum_q    <= acc[RECT_W-1:0];
      out_status_q <= q_status;
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.rect_sum = out_sum_q;
  assign out_ch.status   = out_status_q;

  a_load_goes_to_write: assert property (@(posedge clk) disable iff (rst)
    ld_xfer && !cfg_we |=> state_q == S_LD_WR)
    else $error("load transfer did not reach the write cycle");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done state");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> 32'(ram_wr_addr) < DEPTH)
    else $error("table write beyond depth");

  a_corner_count: assert property (@(posedge clk) disable iff (rst)
    state_q == S_Q_RD |-> k_q <= 3'd4)
    else $error("corner counter overran");

endmodule

### rtl/sat_ram.sv
// generic simple dual port ram with registered read
module sat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
